[rtl/core/rlpm_pkg.sv]
// rlpm_pkg: shared types and constants for the range list parse and match block
// no dependencies; compiled first

package rlpm_pkg;

  localparam int unsigned MAX_ENTRIES     = 16;
  localparam int unsigned MAX_PART_LENGTH = 31;
  localparam int unsigned TOTAL_W         = 5;
  localparam int unsigned LEN_W           = 6;
  localparam int unsigned VAL_W           = 32;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [VAL_W-1:0] MAG_CAP = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    MODE_CHAR  = 2'd0,
    MODE_END   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_STOP   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [VAL_W-1:0] acc;
    logic [LEN_W-1:0] len;
    phase_e           phase;
    logic             neg;
  } part_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] low;
    logic signed [VAL_W-1:0] high;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } ins_t;

endpackage

[rtl/core/rlpm_in_if.sv]
// rlpm_in_if: input channel carrying list characters, commands and queries
// depends on: nothing

interface rlpm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [7:0]         char_code;
  logic signed [31:0] query_value;

  modport source (output valid, output mode, output char_code, output query_value,
                  input ready);
  modport sink   (input valid, input mode, input char_code, input query_value,
                  output ready);
endinterface

[rtl/core/rlpm_out_if.sv]
// rlpm_out_if: result channel carrying status, hit flag and entry count
// depends on: nothing

interface rlpm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       hit;
  logic [4:0] stored_entries;

  modport source (output valid, output status, output hit, output stored_entries,
                  input ready);
  modport sink   (input valid, input status, input hit, input stored_entries,
                  output ready);
endinterface

[rtl/core/range_list_parse_and_match.sv]
// range_list_parse_and_match: one item per transaction, result registered in the cycle after acceptance.
// throughput one item per cycle while the result side keeps up
// (output register takes the next item as the current result is taken).
// queries compare against all cells of the 16-slot chain in the accept cycle.
// reset clears token state, error, entry count and cell valid bits; no clearing pass.
// depends on: rlpm_pkg, rlpm_in_if, rlpm_out_if, rlpm_parser, rlpm_cell

module range_list_parse_and_match (
  input  logic       clk_i,
  input  logic       rst_ni,
  rlpm_in_if.sink    in_i,
  rlpm_out_if.source out_o
);

  localparam int unsigned N = rlpm_pkg::MAX_ENTRIES;

  logic                         fire;
  rlpm_pkg::mode_e              mode;
  rlpm_pkg::ins_t               ins;
  logic [1:0]                   status_nx;
  logic [rlpm_pkg::TOTAL_W-1:0] total_nx;
  logic                         clear;

  rlpm_pkg::entry_t ent_w [N+1];
  logic             vld_w [N+1];
  logic             hit_w [N+1];

  logic                         out_vld_q, out_vld_d;
  logic [1:0]                   status_q;
  logic                         hit_q;
  logic [rlpm_pkg::TOTAL_W-1:0] total_q;

  assign mode       = rlpm_pkg::mode_e'(in_i.mode);
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;
  assign clear      = fire && (mode == rlpm_pkg::MODE_CLEAR);

  rlpm_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .mode_i   (mode),
    .char_i   (in_i.char_code),
    .ins_o    (ins),
    .status_o (status_nx),
    .total_o  (total_nx)
  );

  // newest entry enters at the head, older ones move one cell down
  assign ent_w[0] = ins.ent;
  assign vld_w[0] = 1'b1;
  assign hit_w[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rlpm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ins.valid),
      .clear_i (clear),
      .ent_i   (ent_w[i]),
      .valid_i (vld_w[i]),
      .query_i (in_i.query_value),
      .hit_i   (hit_w[i]),
      .ent_o   (ent_w[i+1]),
      .valid_o (vld_w[i+1]),
      .hit_o   (hit_w[i+1])
    );
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire)             out_vld_d = 1'b1;
    else if (out_o.ready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else         out_vld_q <= out_vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_nx;
      hit_q    <= (mode == rlpm_pkg::MODE_QUERY) && hit_w[N];
      total_q  <= total_nx;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.status         = status_q;
  assign out_o.hit            = hit_q;
  assign out_o.stored_entries = total_q;

endmodule

[rtl/core/rlpm_parser.sv]
// rlpm_parser: token scanner, number accumulation, error and entry count
// depends on: rlpm_pkg

module rlpm_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  rlpm_pkg::mode_e   mode_i,
  input  logic [7:0]        char_i,
  output rlpm_pkg::ins_t    ins_o,
  output logic [1:0]        status_o,
  output logic [rlpm_pkg::TOTAL_W-1:0] total_o
);

  function automatic rlpm_pkg::part_t feed(rlpm_pkg::part_t p, logic [7:0] c);
    rlpm_pkg::part_t r;
    logic            dig;
    logic            spc;
    logic [35:0]     m;
    r   = p;
    dig = (c >= rlpm_pkg::CH_ZERO) && (c <= rlpm_pkg::CH_NINE);
    spc = (c == rlpm_pkg::CH_SPACE) || ((c >= rlpm_pkg::CH_TAB) && (c <= rlpm_pkg::CH_CR));
    m   = '0;
    if (p.len != rlpm_pkg::LEN_MAX) r.len = p.len + 1'b1;
    case (p.phase)
      rlpm_pkg::PH_LEAD: begin
        if (spc) begin
          r.phase = rlpm_pkg::PH_LEAD;
        end else if (c == rlpm_pkg::CH_PLUS || c == rlpm_pkg::CH_DASH) begin
          r.phase = rlpm_pkg::PH_SIGN;
          r.neg   = (c == rlpm_pkg::CH_DASH);
        end else if (dig) begin
          r.phase = rlpm_pkg::PH_DIGITS;
        end else begin
          r.phase = rlpm_pkg::PH_STOP;
        end
      end
      rlpm_pkg::PH_SIGN:   r.phase = dig ? rlpm_pkg::PH_DIGITS : rlpm_pkg::PH_STOP;
      rlpm_pkg::PH_DIGITS: if (!dig) r.phase = rlpm_pkg::PH_STOP;
      default: ;
    endcase
    // acc * 10 + digit, capped at 2^31
    if (r.phase == rlpm_pkg::PH_DIGITS && dig) begin
      m = ({4'b0, p.acc} << 3) + ({4'b0, p.acc} << 1) + {28'b0, c - rlpm_pkg::CH_ZERO};
      r.acc = (m > {4'b0, rlpm_pkg::MAG_CAP}) ? rlpm_pkg::MAG_CAP : m[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] part_value(logic [31:0] acc, logic neg);
    logic signed [31:0] v;
    if (neg) v = acc[31] ? $signed(rlpm_pkg::MAG_CAP) : $signed((~acc) + 32'd1);
    else     v = acc[31] ? $signed(rlpm_pkg::POS_MAX) : $signed(acc);
    return v;
  endfunction

  logic                         active_q, active_d;
  logic                         in_high_q, in_high_d;
  rlpm_pkg::part_t              lo_q, lo_d, hi_q, hi_d;
  rlpm_pkg::status_e            err_q, err_d;
  logic [rlpm_pkg::TOTAL_W-1:0] total_q, total_d;

  logic                         do_finish;
  logic                         bad;
  logic                         gap;
  logic signed [31:0]           lo_val, hi_val;

  always_comb begin
    lo_val = part_value(lo_q.acc, lo_q.neg);
    hi_val = in_high_q ? part_value(hi_q.acc, hi_q.neg) : lo_val;
    bad = (lo_q.len == '0) || (lo_q.len > rlpm_pkg::LEN_W'(rlpm_pkg::MAX_PART_LENGTH));
    if (in_high_q) begin
      bad = bad || (hi_q.len == '0) ||
            (hi_q.len > rlpm_pkg::LEN_W'(rlpm_pkg::MAX_PART_LENGTH));
    end
    bad = bad || (lo_val > hi_val);
    gap = (char_i == rlpm_pkg::CH_SPACE) || (char_i == rlpm_pkg::CH_NL) ||
          (char_i == rlpm_pkg::CH_TAB);
  end

  always_comb begin
    active_d  = active_q;
    in_high_d = in_high_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    err_d     = err_q;
    total_d   = total_q;
    do_finish = 1'b0;
    ins_o.valid    = 1'b0;
    ins_o.ent.low  = lo_val;
    ins_o.ent.high = hi_val;

    if (fire_i) begin
      unique case (mode_i)
        rlpm_pkg::MODE_CHAR: begin
          if (err_q == rlpm_pkg::ST_OK) begin
            if (char_i == rlpm_pkg::CH_NUL || char_i == rlpm_pkg::CH_COMMA) begin
              do_finish = 1'b1;
            end else if (!active_q && gap) begin
              // white space between tokens
            end else begin
              active_d = 1'b1;
              if (char_i == rlpm_pkg::CH_DASH && !in_high_q) begin
                in_high_d = 1'b1;
              end else if (in_high_q) begin
                hi_d = feed(hi_q, char_i);
              end else begin
                lo_d = feed(lo_q, char_i);
              end
            end
          end
        end
        rlpm_pkg::MODE_END: begin
          if (err_q == rlpm_pkg::ST_OK) do_finish = 1'b1;
        end
        rlpm_pkg::MODE_CLEAR: begin
          total_d   = '0;
          err_d     = rlpm_pkg::ST_OK;
          active_d  = 1'b0;
          in_high_d = 1'b0;
          lo_d      = '0;
          hi_d      = '0;
        end
        default: ;
      endcase
    end

    if (do_finish && active_q) begin
      if (bad) begin
        err_d = rlpm_pkg::ST_INVALID;
      end else if (total_q >= rlpm_pkg::TOTAL_W'(rlpm_pkg::MAX_ENTRIES)) begin
        err_d = rlpm_pkg::ST_FULL;
      end else begin
        ins_o.valid = 1'b1;
        total_d     = total_q + 1'b1;
      end
      active_d  = 1'b0;
      in_high_d = 1'b0;
      lo_d      = '0;
      hi_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      in_high_q <= 1'b0;
      lo_q      <= '0;
      hi_q      <= '0;
      err_q     <= rlpm_pkg::ST_OK;
      total_q   <= '0;
    end else begin
      active_q  <= active_d;
      in_high_q <= in_high_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      err_q     <= err_d;
      total_q   <= total_d;
    end
  end

  assign status_o = err_d;
  assign total_o  = total_d;

endmodule

[rtl/core/rlpm_cell.sv]
// rlpm_cell: one table slot of the entry chain, shifts to its neighbour on insert
// depends on: rlpm_pkg

module rlpm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic               clear_i,
  input  rlpm_pkg::entry_t   ent_i,
  input  logic               valid_i,
  input  logic signed [31:0] query_i,
  input  logic               hit_i,
  output rlpm_pkg::entry_t   ent_o,
  output logic               valid_o,
  output logic               hit_o
);

  rlpm_pkg::entry_t ent_q;
  logic             valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) ent_q <= ent_i;
  end

  assign ent_o   = ent_q;
  assign valid_o = valid_q;
  assign hit_o   = hit_i | (valid_q && (query_i >= $signed(ent_q.low)) &&
                                        (query_i <= $signed(ent_q.high)));

endmodule

[tb/sv/tb_top.sv]
// tb_top: self-checking bench for range_list_parse_and_match, with its own list parser and table
// drives list text, end, clear and query transactions under random idling and compares each result
// depends on: rlpm_pkg, rlpm_in_if, rlpm_out_if, range_list_parse_and_match
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 590;

  typedef struct packed {
    rlpm_pkg::status_e status;
    logic              hit;
    logic [4:0]        entries;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rlpm_in_if  in_if ();
  rlpm_out_if out_if ();

  range_list_parse_and_match dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // parser and table as the bench sees them
  rlpm_pkg::entry_t  range_tbl [rlpm_pkg::MAX_ENTRIES];
  int unsigned       range_count = 0;
  logic              tok_open = 1'b0;
  logic              tok_ranged = 1'b0;
  rlpm_pkg::part_t   lo_part = '0;
  rlpm_pkg::part_t   hi_part = '0;
  rlpm_pkg::status_e list_err = rlpm_pkg::ST_OK;

  reply_t      pending_replies[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          sender_gaps = 1'b1;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned quiet_cycles = 0;

  string bad_tokens [7] = '{"-5", "5-", "-", "9-3", "4-x", "+-2", "1-2-3"};

  function automatic void drop_token();
    tok_open   = 1'b0;
    tok_ranged = 1'b0;
    lo_part    = '0;
    hi_part    = '0;
  endfunction

  // strtol-style scan of one character into a number part
  function automatic rlpm_pkg::part_t scan_char(rlpm_pkg::part_t p, logic [7:0] c);
    logic        is_digit;
    logic [63:0] m;
    is_digit = (c >= rlpm_pkg::CH_ZERO) && (c <= rlpm_pkg::CH_NINE);
    if (p.len != rlpm_pkg::LEN_MAX) p.len = p.len + 1'b1;
    case (p.phase)
      rlpm_pkg::PH_LEAD: begin
        if (!((c == rlpm_pkg::CH_SPACE) ||
              (c >= rlpm_pkg::CH_TAB && c <= rlpm_pkg::CH_CR))) begin
          if (c == rlpm_pkg::CH_PLUS || c == rlpm_pkg::CH_DASH) begin
            p.phase = rlpm_pkg::PH_SIGN;
            p.neg   = (c == rlpm_pkg::CH_DASH);
          end else if (is_digit) begin
            p.phase = rlpm_pkg::PH_DIGITS;
          end else begin
            p.phase = rlpm_pkg::PH_STOP;
          end
        end
      end
      rlpm_pkg::PH_SIGN: p.phase = is_digit ? rlpm_pkg::PH_DIGITS : rlpm_pkg::PH_STOP;
      rlpm_pkg::PH_DIGITS: begin
        if (!is_digit) p.phase = rlpm_pkg::PH_STOP;
      end
      default: p.phase = rlpm_pkg::PH_STOP;
    endcase
    if (p.phase == rlpm_pkg::PH_DIGITS && is_digit) begin
      m = 64'(p.acc) * 10 + 64'(c - rlpm_pkg::CH_ZERO);
      p.acc = (m > 64'(rlpm_pkg::MAG_CAP)) ? rlpm_pkg::MAG_CAP : m[31:0];
    end
    return p;
  endfunction

  function automatic logic signed [31:0] part_value(rlpm_pkg::part_t p);
    if (p.acc >= rlpm_pkg::MAG_CAP) return p.neg ? rlpm_pkg::MAG_CAP : rlpm_pkg::POS_MAX;
    return p.neg ? -p.acc : p.acc;
  endfunction

  function automatic void close_token();
    logic                bad;
    logic signed [31:0]  lo;
    logic signed [31:0]  hi;
    if (!tok_open) return;
    bad = (lo_part.len == 0) || (lo_part.len > rlpm_pkg::MAX_PART_LENGTH);
    if (tok_ranged) bad |= (hi_part.len == 0) || (hi_part.len > rlpm_pkg::MAX_PART_LENGTH);
    lo = part_value(lo_part);
    hi = tok_ranged ? part_value(hi_part) : lo;
    if (lo > hi) bad = 1'b1;
    if (bad) begin
      list_err = rlpm_pkg::ST_INVALID;
    end else if (range_count >= rlpm_pkg::MAX_ENTRIES) begin
      list_err = rlpm_pkg::ST_FULL;
    end else begin
      range_tbl[range_count].low  = lo;
      range_tbl[range_count].high = hi;
      range_count++;
    end
    drop_token();
  endfunction

  function automatic reply_t step_range_list(rlpm_pkg::mode_e m, logic [7:0] c,
                                             logic signed [31:0] q);
    reply_t r;
    r.hit = 1'b0;
    case (m)
      rlpm_pkg::MODE_CHAR: begin
        if (list_err == rlpm_pkg::ST_OK) begin
          if (c == rlpm_pkg::CH_NUL || c == rlpm_pkg::CH_COMMA) begin
            close_token();
          end else if (tok_open || !(c == rlpm_pkg::CH_SPACE || c == rlpm_pkg::CH_NL ||
                                     c == rlpm_pkg::CH_TAB)) begin
            tok_open = 1'b1;
            if (c == rlpm_pkg::CH_DASH && !tok_ranged) tok_ranged = 1'b1;
            else if (tok_ranged) hi_part = scan_char(hi_part, c);
            else lo_part = scan_char(lo_part, c);
          end
        end
      end
      rlpm_pkg::MODE_END: begin
        if (list_err == rlpm_pkg::ST_OK) close_token();
      end
      rlpm_pkg::MODE_CLEAR: begin
        range_count = 0;
        list_err    = rlpm_pkg::ST_OK;
        drop_token();
      end
      default: begin
        for (int i = 0; i < range_count; i++) begin
          if (q >= $signed(range_tbl[i].low) && q <= $signed(range_tbl[i].high)) r.hit = 1'b1;
        end
      end
    endcase
    r.status  = list_err;
    r.entries = range_count[4:0];
    return r;
  endfunction

  task automatic send_item(rlpm_pkg::mode_e m, logic [7:0] c, logic signed [31:0] q);
    if (burst_left == 0) begin
      if (sender_gaps) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.mode        <= m;
    in_if.char_code   <= c;
    in_if.query_value <= q;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_replies.push_back(step_range_list(m, c, q));
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(rlpm_pkg::MODE_CHAR, s[i], $urandom);
  endtask

  task automatic send_query(logic signed [31:0] q);
    send_item(rlpm_pkg::MODE_QUERY, $urandom_range(0, 255), q);
  endtask

  task automatic send_clear();
    send_item(rlpm_pkg::MODE_CLEAR, $urandom_range(0, 255), $urandom);
  endtask

  task automatic send_end();
    send_item(rlpm_pkg::MODE_END, $urandom_range(0, 255), $urandom);
  endtask

  task automatic fill_table();
    for (int n = 0; n < rlpm_pkg::MAX_ENTRIES; n++) send_text($sformatf("%0d,", n % 10));
  endtask

  function automatic longint unsigned pick_mag();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return $urandom_range(0, 300);
    if (sel < 9) return $urandom;
    return {$urandom, $urandom};
  endfunction

  // one number part: optional white space, sign, padding zeros and trailing junk
  function automatic string make_part(longint unsigned mag, bit neg);
    string s;
    string ws;
    int    k;
    ws = " \t\n\v\f\r";
    s  = "";
    if ($urandom_range(0, 4) == 0) begin
      k = $urandom_range(0, 5);
      s = {s, ws.substr(k, k)};
    end
    if (neg) s = {s, "-"};
    else if ($urandom_range(0, 5) == 0) s = {s, "+"};
    if ($urandom_range(0, 29) == 0) repeat ($urandom_range(26, 36)) s = {s, "0"};
    s = {s, $sformatf("%0d", mag)};
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) != 0) s = {s, "x"};
      else s = {s, " 7"};
    end
    return s;
  endfunction

  // mostly the edges of stored entries, otherwise anywhere
  function automatic logic signed [31:0] pick_query();
    int unsigned i;
    if (range_count != 0 && $urandom_range(0, 2) != 0) begin
      i = $urandom_range(0, range_count - 1);
      case ($urandom_range(0, 3))
        0: return $signed(range_tbl[i].low) - 1;
        1: return range_tbl[i].low;
        2: return range_tbl[i].high;
        default: return $signed(range_tbl[i].high) + 1;
      endcase
    end
    if ($urandom_range(0, 1) != 0) return $urandom;
    return $urandom_range(0, 400);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    reply_t want;
    if (out_if.valid && out_if.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result with none expected, status %0d hit %0d entries %0d",
                 $time, out_if.status, out_if.hit, out_if.stored_entries);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (out_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_if.status);
          mismatches++;
        end
        if (out_if.hit !== want.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, out_if.hit);
          mismatches++;
        end
        if (out_if.stored_entries !== want.entries) begin
          $display("%0t: stored_entries expected %0d actual %0d",
                   $time, want.entries, out_if.stored_entries);
          mismatches++;
        end
      end
    end
  end

  // result side stalls, with a long hold-off on request
  always @(posedge clk_i) begin
    rx_cycle++;
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_request != 0) begin
      hold_left    = hold_request - 1;
      hold_request = 0;
      out_if.ready <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 4)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) != 0);
        2: out_if.ready <= ($urandom_range(0, 9) != 0);
        default: out_if.ready <= ((rx_cycle % 7) < 4);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic test_values_and_ranges();
    send_text("0, 2147483647,99999999999,\t12x7-40 , +7-+9,1- 5,\v5");
    send_end();
    send_query(0);
    send_query(-1);
    send_query(32'sh7fffffff);
    send_query(32'sh80000000);
    send_query(8);
    send_query(41);
  endtask

  task automatic test_bad_tokens();
    send_clear();
    send_text("9-3,1,");
    send_end();
    send_query(9);
    send_clear();
    send_text("-5,");
    send_clear();
    send_text("2,5-,");
    send_query(2);
    send_clear();
  endtask

  task automatic test_table_full();
    fill_table();
    send_text("7-2,");
    send_query(5);
    send_clear();
    fill_table();
    send_text("3,4,");
    send_query(9);
  endtask

  task automatic test_separators();
    send_clear();
    send_text("\t 4");
    send_item(rlpm_pkg::MODE_CHAR, rlpm_pkg::CH_NUL, $urandom);
    send_end();
    send_text(",, ,x,8");
    send_end();
    send_query(8);
    send_query(0);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    sender_gaps  = 1'b0;
    send_clear();
    hold_request = 300;
    for (int n = 0; n < 15; n++) begin
      send_text($sformatf("%0d-%0d,", n, n + 4));
      send_query(n);
    end
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_lists();
    int unsigned     target;
    int unsigned     pick;
    int unsigned     k;
    longint unsigned lo_mag;
    string           hi_text;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if (list_err != rlpm_pkg::ST_OK && $urandom_range(0, 9) < 7) send_clear();
      else if (range_count == rlpm_pkg::MAX_ENTRIES && $urandom_range(0, 9) < 3) send_clear();
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        send_text(make_part(pick_mag(), 1'b0));
      end else if (pick < 16) begin
        lo_mag = pick_mag();
        if ($urandom_range(0, 9) == 0) hi_text = make_part(pick_mag(), 1'b1);
        else hi_text = make_part(lo_mag + $urandom_range(0, 60), 1'b0);
        send_text({make_part(lo_mag, 1'b0), "-", hi_text});
      end else if (pick == 16) begin
        send_text(bad_tokens[$urandom_range(0, 6)]);
      end else if (pick == 17) begin
        // query in the middle of an open token
        send_text("3");
        send_query(pick_query());
        send_text($sformatf("-%0d", $urandom_range(0, 500)));
      end else if (pick == 18) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(rlpm_pkg::MODE_CHAR, $urandom_range(0, 255), $urandom);
        end
      end else begin
        // clear drops a half-built range
        send_text({make_part(pick_mag(), 1'b0), "-"});
        send_clear();
      end
      k = $urandom_range(0, 9);
      if (k < 6) send_text(",");
      else if (k == 6) send_text(" ,");
      else if (k == 7) send_end();
      else if (k == 8) send_item(rlpm_pkg::MODE_CHAR, rlpm_pkg::CH_NUL, $urandom);
      else send_text(", ,");
      repeat ($urandom_range(0, 3)) send_query(pick_query());
      if ($urandom_range(0, 99) < 5) sender_gaps = !sender_gaps;
    end
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.mode        = rlpm_pkg::MODE_CHAR;
    in_if.char_code   = 8'h00;
    in_if.query_value = '0;
    out_if.ready      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_values_and_ranges();
    test_bad_tokens();
    test_table_full();
    test_separators();
    test_backpressure();
    test_random_lists();

    in_if.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/rlpm_pkg.sv
rtl/core/rlpm_in_if.sv
rtl/core/rlpm_out_if.sv
rtl/core/rlpm_parser.sv
rtl/core/rlpm_cell.sv
rtl/core/range_list_parse_and_match.sv
tb/sv/tb_top.sv
